@@ rtl/qks_pkg.sv @@
// ----------------------------------------------------------------------------
// qks_pkg
// Shared types, constants and helpers of the quantized keyframe sampler.
// ----------------------------------------------------------------------------
package qks_pkg;

  // Sample bank geometry. The bank is addressed modulo its depth.
  localparam int BANK_WORDS = 65536;
  localparam int BANK_AW    = $clog2(BANK_WORDS);

  localparam int CH_W     = 4;
  localparam int MODE_W   = 2;
  localparam int FRAC_W   = 8;
  localparam int SHIFT_W  = 5;
  localparam int SAMPLE_W = 16;
  localparam int NUM_W    = 26;
  localparam int VALUE_W  = 33;

  // Register indexes on the configuration port.
  localparam logic [3:0] REG_FRAME_COUNT = 4'd0;
  localparam logic [3:0] REG_SHIFT_A     = 4'd1;
  localparam logic [3:0] REG_SHIFT_B     = 4'd2;
  localparam logic [3:0] REG_SHIFT_C     = 4'd3;

  // Channel walk.
  localparam logic [CH_W-1:0] LAST_CH       = 4'd8;
  localparam logic [CH_W-1:0] GROUP_B_FIRST = 4'd3;
  localparam logic [CH_W-1:0] GROUP_C_FIRST = 4'd6;

  // Channel modes.
  localparam logic [MODE_W-1:0] MODE_DEFAULT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONSTANT = 2'd1;

  // Request opcodes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Default value of the last group, 1.0 with 16 fraction bits.
  localparam logic signed [VALUE_W-1:0] DEFAULT_ONE = 33'sd65536;
  localparam logic [SHIFT_W-1:0]        SHIFT_UNITY = 5'd8;

  typedef struct packed {
    logic [15:0]        frame_count;
    logic [SHIFT_W-1:0] shift_a;
    logic [SHIFT_W-1:0] shift_b;
    logic [SHIFT_W-1:0] shift_c;
  } cfg_t;

  // Control that travels down the pipeline with each channel.
  typedef struct packed {
    logic               vld;
    logic [CH_W-1:0]    ch;
    logic [MODE_W-1:0]  mode;
    logic [FRAC_W-1:0]  frac;
    logic [SHIFT_W-1:0] shift;
  } lane_t;

  // Reduces a 17-bit halfword index to a bank address (modulo the depth).
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [16:0] v);
    logic [BANK_AW+16:0] w;
    w = {{BANK_AW{1'b0}}, v};
    return w[BANK_AW-1:0];
  endfunction

endpackage

@@ rtl/qks_seq.sv @@
// ----------------------------------------------------------------------------
// qks_seq
// Request sequencer: takes words, writes the bank, walks the nine channels.
// ----------------------------------------------------------------------------
module qks_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  qks_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_opcode,
  input  logic [15:0]                          in_bank_address,
  input  logic [15:0]                          in_bank_data,
  input  logic [17:0]                          in_channel_modes,
  input  logic [15:0]                          in_data_offset,
  input  logic [15:0]                          in_frame_whole,
  input  logic [7:0]                           in_frame_fraction,
  output logic                                 wr_en,
  output logic [qks_pkg::BANK_AW-1:0]          wr_addr,
  output logic [qks_pkg::SAMPLE_W-1:0]         wr_data,
  output logic [qks_pkg::BANK_AW-1:0]          rd_addr_a,
  output logic [qks_pkg::BANK_AW-1:0]          rd_addr_b,
  output qks_pkg::lane_t                       lane
);

  logic                                busy_r,  busy_nxt;
  logic [qks_pkg::CH_W-1:0]            ch_r,    ch_nxt;
  logic [qks_pkg::BANK_AW-1:0]         addr_r,  addr_nxt;
  logic [qks_pkg::BANK_AW-1:0]         whole_r, whole_nxt;
  logic [17:0]                         modes_r, modes_nxt;
  logic [qks_pkg::FRAC_W-1:0]          frac_r,  frac_nxt;

  logic                                accept;
  logic                                issue;
  logic                                last_frame;
  logic [qks_pkg::MODE_W-1:0]          mode;
  logic [qks_pkg::BANK_AW-1:0]         stride;
  logic [qks_pkg::BANK_AW-1:0]         addr_step;

  assign in_ready = adv && (!busy_r || ch_r == qks_pkg::LAST_CH);
  assign accept   = in_valid && in_ready;
  assign issue    = adv && busy_r;

  assign wr_en   = accept && in_opcode == qks_pkg::OP_WRITE;
  assign wr_addr = qks_pkg::bank_addr({1'b0, in_bank_address});
  assign wr_data = in_bank_data;

  assign mode   = modes_r[2*ch_r +: 2];
  assign stride = qks_pkg::bank_addr({1'b0, cfg.frame_count} + 17'd1);

  // The fraction is dropped on the last frame of the animation.
  assign last_frame = cfg.frame_count != 16'd0
                      && in_frame_whole == cfg.frame_count - 16'd1;

  always_comb begin
    rd_addr_a = addr_r;
    addr_step = addr_r;
    unique case (mode)
      qks_pkg::MODE_DEFAULT: begin
        addr_step = addr_r;
      end
      qks_pkg::MODE_CONSTANT: begin
        addr_step = addr_r + qks_pkg::BANK_AW'(1);
      end
      default: begin
        rd_addr_a = addr_r + whole_r;
        addr_step = addr_r + stride;
      end
    endcase
  end

  // A constant channel reads a single sample, so both ports point at it.
  assign rd_addr_b = (mode == qks_pkg::MODE_CONSTANT) ? rd_addr_a
                                                       : rd_addr_a + qks_pkg::BANK_AW'(1);

  always_comb begin
    lane.vld  = issue;
    lane.ch   = ch_r;
    lane.mode = mode;
    lane.frac = (mode == qks_pkg::MODE_CONSTANT) ? '0 : frac_r;
    if (ch_r < qks_pkg::GROUP_B_FIRST) begin
      lane.shift = cfg.shift_a;
    end else if (ch_r < qks_pkg::GROUP_C_FIRST) begin
      lane.shift = cfg.shift_b;
    end else begin
      lane.shift = cfg.shift_c;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    ch_nxt    = ch_r;
    addr_nxt  = addr_r;
    whole_nxt = whole_r;
    modes_nxt = modes_r;
    frac_nxt  = frac_r;
    if (issue) begin
      ch_nxt   = ch_r + 4'd1;
      addr_nxt = addr_step;
      if (ch_r == qks_pkg::LAST_CH) begin
        busy_nxt = 1'b0;
      end
    end
    // A new request can load in the cycle the last channel issues.
    if (accept && in_opcode == qks_pkg::OP_SAMPLE) begin
      busy_nxt  = 1'b1;
      ch_nxt    = '0;
      addr_nxt  = qks_pkg::bank_addr({1'b0, in_data_offset});
      whole_nxt = qks_pkg::bank_addr({1'b0, in_frame_whole});
      modes_nxt = in_channel_modes;
      frac_nxt  = last_frame ? '0 : in_frame_fraction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ch_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      ch_r   <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    whole_r <= whole_nxt;
    modes_r <= modes_nxt;
    frac_r  <= frac_nxt;
  end

endmodule

@@ rtl/qks_bank.sv @@
// ----------------------------------------------------------------------------
// qks_bank
// Sample bank: one write port, two registered read ports, and the read stage.
// ----------------------------------------------------------------------------
module qks_bank (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 wr_en,
  input  logic [qks_pkg::BANK_AW-1:0]          wr_addr,
  input  logic [qks_pkg::SAMPLE_W-1:0]         wr_data,
  input  logic [qks_pkg::BANK_AW-1:0]          rd_addr_a,
  input  logic [qks_pkg::BANK_AW-1:0]          rd_addr_b,
  input  qks_pkg::lane_t                       lane_in,
  output logic [qks_pkg::SAMPLE_W-1:0]         rd_data_a,
  output logic [qks_pkg::SAMPLE_W-1:0]         rd_data_b,
  output qks_pkg::lane_t                       lane_out
);

  logic [qks_pkg::SAMPLE_W-1:0] mem [qks_pkg::BANK_WORDS];
  logic [qks_pkg::SAMPLE_W-1:0] rd_a_r;
  logic [qks_pkg::SAMPLE_W-1:0] rd_b_r;
  qks_pkg::lane_t               lane_r;

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else if (adv) begin
      lane_r.vld <= lane_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r.ch    <= lane_in.ch;
      lane_r.mode  <= lane_in.mode;
      lane_r.frac  <= lane_in.frac;
      lane_r.shift <= lane_in.shift;
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;
  assign lane_out  = lane_r;

endmodule

@@ rtl/qks_arith.sv @@
// ----------------------------------------------------------------------------
// qks_arith
// Interpolation stage, dequantize shift stage and the output word register.
// ----------------------------------------------------------------------------
module qks_arith (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic [qks_pkg::SAMPLE_W-1:0]         rd_data_a,
  input  logic [qks_pkg::SAMPLE_W-1:0]         rd_data_b,
  input  qks_pkg::lane_t                       lane_in,
  output logic                                 out_valid,
  output logic [qks_pkg::CH_W-1:0]             out_channel_index,
  output logic signed [qks_pkg::VALUE_W-1:0]   out_channel_value,
  output logic                                 out_last_channel
);

  // Interpolation: num = a*256 + (b-a)*f.
  logic signed [16:0]                       diff;
  logic signed [qks_pkg::NUM_W-1:0]         prod;
  logic signed [qks_pkg::NUM_W-1:0]         num;
  logic signed [qks_pkg::NUM_W-1:0]         num_r;
  qks_pkg::lane_t                           lane_r;

  assign diff = $signed({rd_data_b[15], rd_data_b}) - $signed({rd_data_a[15], rd_data_a});
  assign prod = qks_pkg::NUM_W'(diff * $signed({1'b0, lane_in.frac}));
  assign num  = $signed({{2{rd_data_a[15]}}, rd_data_a, 8'd0}) + prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else if (adv) begin
      lane_r.vld <= lane_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r.ch    <= lane_in.ch;
      lane_r.mode  <= lane_in.mode;
      lane_r.frac  <= lane_in.frac;
      lane_r.shift <= lane_in.shift;
      num_r        <= num;
    end
  end

  // Dequantize: scale by 2^(8-shift), flooring on a right shift.
  logic signed [qks_pkg::VALUE_W-1:0] num_ext;
  logic signed [qks_pkg::VALUE_W-1:0] value;
  logic [qks_pkg::SHIFT_W-1:0]        sh_left;
  logic [qks_pkg::SHIFT_W-1:0]        sh_right;

  assign num_ext  = {{(qks_pkg::VALUE_W-qks_pkg::NUM_W){num_r[qks_pkg::NUM_W-1]}}, num_r};
  assign sh_left  = qks_pkg::SHIFT_UNITY - lane_r.shift;
  assign sh_right = lane_r.shift - qks_pkg::SHIFT_UNITY;

  always_comb begin
    if (lane_r.mode == qks_pkg::MODE_DEFAULT) begin
      value = (lane_r.ch < qks_pkg::GROUP_C_FIRST) ? '0 : qks_pkg::DEFAULT_ONE;
    end else if (lane_r.shift <= qks_pkg::SHIFT_UNITY) begin
      value = num_ext <<< sh_left;
    end else begin
      value = num_ext >>> sh_right;
    end
  end

  logic                                 out_valid_r;
  logic [qks_pkg::CH_W-1:0]             out_ch_r;
  logic signed [qks_pkg::VALUE_W-1:0]   out_value_r;
  logic                                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= lane_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r    <= lane_r.ch;
      out_value_r <= value;
      out_last_r  <= lane_r.ch == qks_pkg::LAST_CH;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_channel_value = out_value_r;
  assign out_last_channel  = out_last_r;

endmodule

@@ rtl/quantized_keyframe_sampler.sv @@
// ----------------------------------------------------------------------------
// quantized_keyframe_sampler
// Keyframe sampler over a bank of quantized 16-bit samples, nine channels.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one request word. A write
// word (opcode 0) stores one halfword into the sample bank and produces no
// result. A sample word (opcode 1) produces nine result words on the output
// channel (out_valid/out_ready), channels 0 through 8 in order, with
// out_last_channel set on channel 8.
// A sample word is loaded into the channel sequencer, which issues one
// channel per cycle, while the pipeline advances, into a four-stage
// pipeline: address walk, bank read (two ports, registered), interpolation
// multiply, dequantize shift into the output register. Result words leave
// the output register one per cycle while the pipeline advances. The
// sequencer takes the next request in the cycle its last channel issues, so
// a new request enters while the previous one's channels are in the pipeline.
// When out_ready is low with a word waiting, the whole pipeline holds and
// in_ready drops; no word is lost or repeated.
// Synchronous reset (rst_n low) empties the pipeline and restores the
// registers: frame_count 1, shifts 5, 11 and 10. The bank is not cleared;
// entries must be written before they are sampled. Configuration words on
// cfg_we/cfg_index/cfg_data are taken at once; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module quantized_keyframe_sampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [3:0]                           cfg_index,
  input  logic [15:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_opcode,
  input  logic [15:0]                          in_bank_address,
  input  logic [15:0]                          in_bank_data,
  input  logic [17:0]                          in_channel_modes,
  input  logic [15:0]                          in_data_offset,
  input  logic [15:0]                          in_frame_whole,
  input  logic [7:0]                           in_frame_fraction,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [3:0]                           out_channel_index,
  output logic signed [32:0]                   out_channel_value,
  output logic                                 out_last_channel
);

  qks_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        qks_pkg::REG_FRAME_COUNT: cfg_nxt.frame_count = cfg_data;
        qks_pkg::REG_SHIFT_A:     cfg_nxt.shift_a     = cfg_data[qks_pkg::SHIFT_W-1:0];
        qks_pkg::REG_SHIFT_B:     cfg_nxt.shift_b     = cfg_data[qks_pkg::SHIFT_W-1:0];
        qks_pkg::REG_SHIFT_C:     cfg_nxt.shift_c     = cfg_data[qks_pkg::SHIFT_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count <= 16'd1;
      cfg_r.shift_a     <= 5'd5;
      cfg_r.shift_b     <= 5'd11;
      cfg_r.shift_c     <= 5'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The whole pipeline moves together unless a result word is held.
  logic adv;
  assign adv = !out_valid || out_ready;

  logic                                 wr_en;
  logic [qks_pkg::BANK_AW-1:0]          wr_addr;
  logic [qks_pkg::SAMPLE_W-1:0]         wr_data;
  logic [qks_pkg::BANK_AW-1:0]          rd_addr_a;
  logic [qks_pkg::BANK_AW-1:0]          rd_addr_b;
  logic [qks_pkg::SAMPLE_W-1:0]         rd_data_a;
  logic [qks_pkg::SAMPLE_W-1:0]         rd_data_b;
  qks_pkg::lane_t                       lane_issue;
  qks_pkg::lane_t                       lane_read;

  qks_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_bank_address   (in_bank_address),
    .in_bank_data      (in_bank_data),
    .in_channel_modes  (in_channel_modes),
    .in_data_offset    (in_data_offset),
    .in_frame_whole    (in_frame_whole),
    .in_frame_fraction (in_frame_fraction),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .lane              (lane_issue)
  );

  qks_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .lane_in   (lane_issue),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .lane_out  (lane_read)
  );

  qks_arith u_arith (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .rd_data_a         (rd_data_a),
    .rd_data_b         (rd_data_b),
    .lane_in           (lane_read),
    .out_valid         (out_valid),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_channel  (out_last_channel)
  );

endmodule
